/* hw/rtl/dwcs_pkg.sv */
// Shared types and constants of the waveform command sequencer.
package dwcs_pkg;

    // Field widths of one request and one command word.
    localparam int FREQ_W  = 28;
    localparam int SEL_W   = 2;
    localparam int MODE_W  = 2;
    localparam int PHASE_W = 14;
    localparam int WORD_W  = 16;
    localparam int HALF_W  = 14;

    // Tuning word = floor(freq_q4 * TW_NUM / TW_DEN).
    // TW_NUM is the truncated quotient 2^28 / 25 and TW_DEN carries the
    // 1 MHz scale together with the four fractional frequency bits.
    localparam logic [23:0] TW_NUM = 24'd10737418;
    localparam logic [23:0] TW_DEN = 24'd16000000;

    // Reciprocal floor(2^53 / TW_DEN) used to estimate the quotient.
    localparam logic [29:0] TW_RECIP = 30'd562949953;

    // Register select codes.
    localparam logic [SEL_W-1:0] SEL_REG0 = 2'd0;
    localparam logic [SEL_W-1:0] SEL_REG1 = 2'd1;

    // Wave mode codes.
    localparam logic [MODE_W-1:0] MODE_TRI  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SQU  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SIN  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    // Command words and tags.
    localparam logic [WORD_W-1:0] CMD_RESET  = 16'h0100;
    localparam logic [WORD_W-1:0] CMD_B28RST = 16'h2100;
    localparam logic [WORD_W-1:0] CMD_TRI    = 16'h2002;
    localparam logic [WORD_W-1:0] CMD_SQU    = 16'h2028;
    localparam logic [WORD_W-1:0] CMD_SIN    = 16'h2000;
    localparam logic [1:0]        TAG_REG0   = 2'b01;
    localparam logic [1:0]        TAG_REG1   = 2'b10;
    localparam logic [1:0]        TAG_PHASE  = 2'b11;

    // Request fields that ride along with the tuning word computation.
    typedef struct packed {
        logic [SEL_W-1:0]   reg_select;
        logic [MODE_W-1:0]  wave_mode;
        logic [PHASE_W-1:0] phase_value;
    } t_req_ctl;

    // Finished request handed from the arithmetic pipeline to the sequencer.
    typedef struct packed {
        logic [FREQ_W-1:0] tw;
        t_req_ctl          ctl;
    } t_tw_item;

endpackage

/* hw/rtl/dwcs_if.sv */
// Handshake interfaces for the request channel and the command word channel.
interface dwcs_req_if;
    import dwcs_pkg::*;
    logic               valid;
    logic               ready;
    logic [FREQ_W-1:0]  freq_q4;
    logic [SEL_W-1:0]   reg_select;
    logic [MODE_W-1:0]  wave_mode;
    logic [PHASE_W-1:0] phase_value;

    modport source (output valid, output freq_q4, output reg_select, output wave_mode,
                    output phase_value, input ready);
    modport sink (input valid, input freq_q4, input reg_select, input wave_mode,
                  input phase_value, output ready);
endinterface

interface dwcs_word_if;
    import dwcs_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;
    logic              last;

    modport source (output valid, output word, output last, input ready);
    modport sink (input valid, input word, input last, output ready);
endinterface

/* hw/rtl/dwcs_tw_pipe.sv */
// Five-stage pipeline that computes the 28-bit tuning word of each request.
module dwcs_tw_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dwcs_req_if.sink          i_req,
    output logic              o_tw_valid,
    input  logic              i_tw_ready,
    output dwcs_pkg::t_tw_item o_tw_item
);
    import dwcs_pkg::*;

    localparam int PP_W   = HALF_W + 24;
    localparam int PROD_W = 52;
    localparam int MUL_W  = 62;
    localparam int REM_W  = 26;
    localparam logic [REM_W-1:0] REM_LIMIT = REM_W'(2 * 16000000);

    logic              w_en;
    logic [4:0]        r_v;
    t_req_ctl          r_ctl [0:4];

    logic [PP_W-1:0]   r_pp_hi;
    logic [PP_W-1:0]   r_pp_lo;
    logic [PROD_W-1:0] r_p;
    logic [MUL_W-1:0]  r_mul;
    logic [REM_W-1:0]  r_plo3;
    logic [REM_W-1:0]  r_plo4;
    logic [FREQ_W-1:0] r_q4;
    logic [REM_W-1:0]  r_qd4;
    logic [FREQ_W-1:0] r_tw;

    logic [FREQ_W-1:0] w_q;
    logic [PROD_W-1:0] w_qd;
    logic [REM_W-1:0]  w_rem;

    // The whole pipe moves together; it halts only when the last stage is held.
    assign w_en        = !r_v[4] || i_tw_ready;
    assign i_req.ready = w_en;

    // Quotient estimate is exact or one low; the remainder fixes it.
    assign w_q   = r_mul[60:33];
    assign w_qd  = PROD_W'(w_q) * PROD_W'(TW_DEN);
    assign w_rem = r_plo4 - r_qd4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[3:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // Stage 1: two 14 x 24 partial products of freq * TW_NUM.
            r_pp_hi  <= PP_W'(i_req.freq_q4[FREQ_W-1:HALF_W]) * PP_W'(TW_NUM);
            r_pp_lo  <= PP_W'(i_req.freq_q4[HALF_W-1:0]) * PP_W'(TW_NUM);
            r_ctl[0] <= '{reg_select: i_req.reg_select, wave_mode: i_req.wave_mode,
                          phase_value: i_req.phase_value};
            // Stage 2: full product.
            r_p      <= {r_pp_hi[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}} + PROD_W'(r_pp_lo);
            // Stage 3: reciprocal multiply of the top 32 product bits.
            r_mul    <= MUL_W'(r_p[PROD_W-1:20]) * MUL_W'(TW_RECIP);
            r_plo3   <= r_p[REM_W-1:0];
            // Stage 4: estimate times divisor, low bits only.
            r_q4     <= w_q;
            r_qd4    <= w_qd[REM_W-1:0];
            r_plo4   <= r_plo3;
            // Stage 5: one correction step.
            r_tw     <= r_q4 + FREQ_W'(w_rem >= REM_W'(TW_DEN));
            for (int i = 1; i < 5; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    assign o_tw_valid = r_v[4];
    assign o_tw_item  = '{tw: r_tw, ctl: r_ctl[4]};

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_v[0])
        else $error("accepted request did not enter the pipe");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] |-> (w_rem < REM_LIMIT))
        else $error("quotient estimate off by more than one");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && !i_tw_ready) |=> (r_v[4] && $stable(r_tw)))
        else $error("held tuning word changed under stall");

endmodule

/* hw/rtl/dwcs_emit.sv */
// Sequencer that turns one finished request into its run of command words.
module dwcs_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tw_valid,
    output logic               o_tw_ready,
    input  dwcs_pkg::t_tw_item i_tw_item,
    dwcs_word_if.source        o_word
);
    import dwcs_pkg::*;

    localparam logic [2:0] ST_RESET = 3'd0;
    localparam logic [2:0] ST_B28   = 3'd1;
    localparam logic [2:0] ST_LO    = 3'd2;
    localparam logic [2:0] ST_HI    = 3'd3;
    localparam logic [2:0] ST_PHASE = 3'd4;
    localparam logic [2:0] ST_MODE  = 3'd5;

    logic              r_busy;
    logic [2:0]        r_step;
    t_tw_item          r_item;
    logic              r_ovalid;
    logic [WORD_W-1:0] r_word;
    logic              r_last;

    logic              w_slot_free;
    logic              w_load;
    logic              w_take;
    logic              w_freq_wr;
    logic              w_mode_wr;
    logic [2:0]        w_next;
    logic              w_done;
    logic [1:0]        w_tag;
    logic [WORD_W-1:0] w_word;

    assign w_slot_free = !r_ovalid || o_word.ready;
    assign w_load      = r_busy && w_slot_free;
    assign w_freq_wr   = (r_item.ctl.reg_select == SEL_REG0) ||
                         (r_item.ctl.reg_select == SEL_REG1);
    assign w_mode_wr   = (r_item.ctl.wave_mode != MODE_NONE);
    assign w_tag       = (r_item.ctl.reg_select == SEL_REG0) ? TAG_REG0 : TAG_REG1;
    assign w_take      = i_tw_valid && (!r_busy || (w_load && w_done));
    assign o_tw_ready  = !r_busy || (w_load && w_done);

    always_comb begin
        w_next = ST_RESET;
        w_done = 1'b0;
        unique case (r_step)
            ST_RESET: w_next = ST_B28;
            ST_B28: begin
                if (w_freq_wr) begin
                    w_next = ST_LO;
                end else if (w_mode_wr) begin
                    w_next = ST_MODE;
                end else begin
                    w_done = 1'b1;
                end
            end
            ST_LO: w_next = ST_HI;
            ST_HI: w_next = ST_PHASE;
            ST_PHASE: begin
                if (w_mode_wr) begin
                    w_next = ST_MODE;
                end else begin
                    w_done = 1'b1;
                end
            end
            ST_MODE: w_done = 1'b1;
            default: w_done = 1'b1;
        endcase
    end

    always_comb begin
        unique case (r_step)
            ST_RESET: w_word = CMD_RESET;
            ST_B28:   w_word = CMD_B28RST;
            ST_LO:    w_word = {w_tag, r_item.tw[HALF_W-1:0]};
            ST_HI:    w_word = {w_tag, r_item.tw[FREQ_W-1:HALF_W]};
            ST_PHASE: w_word = {TAG_PHASE, r_item.ctl.phase_value};
            ST_MODE: begin
                case (r_item.ctl.wave_mode)
                    MODE_TRI: w_word = CMD_TRI;
                    MODE_SQU: w_word = CMD_SQU;
                    default:  w_word = CMD_SIN;
                endcase
            end
            default:  w_word = CMD_RESET;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= ST_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (w_take) begin
                r_busy <= 1'b1;
                r_step <= ST_RESET;
            end else if (w_load) begin
                r_busy <= !w_done;
                r_step <= w_done ? ST_RESET : w_next;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_word.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_tw_item;
        end
        if (w_load) begin
            r_word <= w_word;
            r_last <= w_done;
        end
    end

    assign o_word.valid = r_ovalid;
    assign o_word.word  = r_word;
    assign o_word.last  = r_last;

    a_run_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_last) |-> r_busy)
        else $error("run lost its remaining words");

    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_step == ST_RESET))
        else $error("idle sequencer not at run start");

    a_take_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (!r_busy || (w_load && w_done)))
        else $error("new request taken while a run is in progress");

endmodule

/* hw/rtl/dds_waveform_command_sequencer.sv */
// Top level of the waveform command sequencer: tuning word pipe and word sequencer.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+----------------------------------------------
//  i_req    | in  | valid/ready  | freq_q4[27:0] reg_select[1:0] wave_mode[1:0]
//           |     |              | phase_value[13:0]
//  o_word   | out | valid/ready  | word[15:0] last
//
// A request transfer enters a five-stage arithmetic pipe (two partial products,
// their sum, a reciprocal multiply, estimate times divisor, and a remainder
// correction), so a new request can be taken every cycle while the pipe has room.
// The sequencer then sends two to six words, one per cycle while o_word does not
// stall, so sustained rate is set by the run length. The first word of a run
// reaches the output through the five pipe stages, the sequencer's request
// register and its output register.
// Reset is synchronous and active low; it empties the pipe and the sequencer.
// When o_word stalls, the output register holds its word, the sequencer stops,
// and the pipe halts once its last stage holds a finished request.
module dds_waveform_command_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dwcs_req_if.sink    i_req,
    dwcs_word_if.source o_word
);
    import dwcs_pkg::*;

    // Finished tuning word plus the request fields, pipe to sequencer.
    logic     w_tw_valid;
    logic     w_tw_ready;
    t_tw_item w_tw_item;

    dwcs_tw_pipe u_tw_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_tw_valid (w_tw_valid),
        .i_tw_ready (w_tw_ready),
        .o_tw_item  (w_tw_item)
    );

    dwcs_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tw_valid (w_tw_valid),
        .o_tw_ready (w_tw_ready),
        .i_tw_item  (w_tw_item),
        .o_word     (o_word)
    );

    // A run always opens with the reset command, so the word offered right
    // after the final word of a run is the reset command of the next one.
    a_run_opens_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.ready && o_word.last) |=>
        (!o_word.valid || o_word.word == CMD_RESET))
        else $error("run did not start with the reset command");

    // The reset command never closes a run.
    a_reset_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.word == CMD_RESET) |-> !o_word.last)
        else $error("reset command marked as the end of a run");

    // The reset command is always followed by the B28 command.
    a_b28_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.ready && o_word.word == CMD_RESET) |=>
        (o_word.valid && o_word.word == CMD_B28RST))
        else $error("reset command not followed by the B28 command");

endmodule
